@@ design/lpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared constants and types for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  // Header layout: one flag byte, then a 32-bit big-endian length
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned HDR_CNT_W    = 3;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [LEN_W-1:0] DEFAULT_MAX_MESSAGE_SIZE = LEN_W'(4 * 1024 * 1024);

  // Last header byte position (count of bytes already taken)
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  // One result from the parser to the output stage
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_valid;
    logic              message_end;
    logic              empty_message;
    logic              too_large;
  } lpmd_result_t;

endpackage

@@ design/lpmd_parser.sv @@
// ----------------------------------------------------------------------------
// lpmd_parser
// Per-byte framing state: header assembly, length check, payload count and
// the sticky closed flag. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module lpmd_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic [lpmd_pkg::BYTE_W-1:0]         data_byte,
  input  logic [lpmd_pkg::LEN_W-1:0]          max_message_size,
  output lpmd_pkg::lpmd_result_t              res
);
  import lpmd_pkg::*;

  logic [HDR_CNT_W-1:0] header_count_r, header_count_nxt;
  logic [LEN_W-1:0]     length_shift_r, length_shift_nxt;
  logic [LEN_W-1:0]     bytes_remaining_r, bytes_remaining_nxt;
  logic                 in_payload_r, in_payload_nxt;
  logic                 closed_r, closed_nxt;
  logic [LEN_W-1:0]     len_full;

  // Length with this byte shifted in (flag byte is not shifted in)
  always_comb begin
    if (header_count_r != '0) begin
      len_full = {length_shift_r[LEN_W-BYTE_W-1:0], data_byte};
    end else begin
      len_full = length_shift_r;
    end
  end

  // Next state and result
  always_comb begin
    header_count_nxt    = header_count_r;
    length_shift_nxt    = length_shift_r;
    bytes_remaining_nxt = bytes_remaining_r;
    in_payload_nxt      = in_payload_r;
    closed_nxt          = closed_r;
    res                 = '0;

    if (take && !closed_r) begin
      if (!in_payload_r) begin
        if (header_count_r != HDR_LAST) begin
          // still collecting header bytes
          header_count_nxt = header_count_r + HDR_CNT_W'(1);
          length_shift_nxt = len_full;
        end else begin
          // header complete: check the declared length
          header_count_nxt    = '0;
          length_shift_nxt    = '0;
          bytes_remaining_nxt = '0;
          priority if (len_full > max_message_size) begin
            closed_nxt    = 1'b1;
            res.valid     = 1'b1;
            res.too_large = 1'b1;
          end else if (len_full == '0) begin
            res.valid         = 1'b1;
            res.message_end   = 1'b1;
            res.empty_message = 1'b1;
          end else begin
            bytes_remaining_nxt = len_full;
            in_payload_nxt      = 1'b1;
          end
        end
      end else begin
        // payload byte passes through
        res.valid        = 1'b1;
        res.payload_byte = data_byte;
        res.byte_valid   = 1'b1;
        bytes_remaining_nxt = bytes_remaining_r - LEN_W'(1);
        if (bytes_remaining_r == LEN_W'(1)) begin
          res.message_end = 1'b1;
          in_payload_nxt  = 1'b0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r    <= '0;
      length_shift_r    <= '0;
      bytes_remaining_r <= '0;
      in_payload_r      <= 1'b0;
      closed_r          <= 1'b0;
    end else begin
      header_count_r    <= header_count_nxt;
      length_shift_r    <= length_shift_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      in_payload_r      <= in_payload_nxt;
      closed_r          <= closed_nxt;
    end
  end

endmodule

@@ design/length_prefixed_message_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into length-prefixed messages (5-byte header).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stream byte per transaction (in_data_byte).
//   out_* : one result per payload byte, per empty message, or once for an
//           oversized length (out_too_large); header bytes give no result.
//   cfg_* : write of max_message_size; always ready. Write only while idle.
// A result appears in the output register in the cycle after its byte
//   is accepted. Throughput: one byte per cycle, set by the single output
//   register; in_ready is high whenever that register is empty or drains in
//   the same cycle.
// Stall: while out_valid is high and out_ready low, in_ready drops and the
//   result holds unchanged.
// Reset (rst_n low, synchronous): header expected, block open, output empty,
//   max_message_size back to 4 MiB. After an oversized length the block
//   drops every byte until reset.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lpmd_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lpmd_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                         out_byte_valid,
  output logic                         out_message_end,
  output logic                         out_empty_message,
  output logic                         out_too_large,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lpmd_pkg::LEN_W-1:0]   cfg_max_message_size
);
  import lpmd_pkg::*;

  logic [LEN_W-1:0] max_size_r;
  lpmd_result_t     res;
  lpmd_result_t     out_r, out_nxt;
  logic             take;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= DEFAULT_MAX_MESSAGE_SIZE;
    end else if (cfg_valid) begin
      max_size_r <= cfg_max_message_size;
    end
  end

  // Input transaction when the output register can take a result
  assign in_ready = !out_r.valid || out_ready;
  assign take     = in_valid && in_ready;

  lpmd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .data_byte        (in_data_byte),
    .max_message_size (max_size_r),
    .res              (res)
  );

  // Output register: load on new result, clear when drained
  always_comb begin
    out_nxt = out_r;
    if (take) begin
      out_nxt = res;
    end else if (out_ready) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else begin
      out_r <= out_nxt;
    end
  end

  assign out_valid         = out_r.valid;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_byte_valid    = out_r.byte_valid;
  assign out_message_end   = out_r.message_end;
  assign out_empty_message = out_r.empty_message;
  assign out_too_large     = out_r.too_large;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed message deframer. A queue of
// stream bytes feeds a valid/ready driver; a deframing predictor runs on
// every accepted byte and the monitor checks each result against it.
// ----------------------------------------------------------------------------
module testbench;

  import lpmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BYTES  = 130;
  localparam int unsigned IDLE_PERCENT = 23;

  // One predicted or observed result
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_valid;
    logic              message_end;
    logic              empty_message;
    logic              too_large;
  } frame_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_payload_byte;
  logic              out_byte_valid;
  logic              out_message_end;
  logic              out_empty_message;
  logic              out_too_large;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_max_message_size = '0;

  length_prefixed_message_deframer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_payload_byte     (out_payload_byte),
    .out_byte_valid       (out_byte_valid),
    .out_message_end      (out_message_end),
    .out_empty_message    (out_empty_message),
    .out_too_large        (out_too_large),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_message_size (cfg_max_message_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stream bytes waiting for the driver, results waiting for the monitor
  logic [BYTE_W-1:0] stream_q[$];
  frame_result_t     frame_result_q[$];

  int unsigned queued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  bit          in_fire    = 1'b0;
  bit          calm       = 1'b0;

  // Deframer predictor state
  logic [HDR_CNT_W-1:0] hdr_cnt   = '0;
  logic [LEN_W-1:0]     len_acc   = '0;
  logic [LEN_W-1:0]     remain    = '0;
  logic                 in_body   = 1'b0;
  logic                 closed    = 1'b0;
  logic [LEN_W-1:0]     limit_len = DEFAULT_MAX_MESSAGE_SIZE;

  frame_result_t got, want;

  task automatic count_error(input string msg);
    begin
      if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
      err_cnt++;
    end
  endtask

  task automatic push_result(input logic [BYTE_W-1:0] pb, input logic bv, input logic me,
                             input logic em, input logic tl);
    frame_result_t r;
    begin
      r = '{payload_byte: pb, byte_valid: bv, message_end: me,
            empty_message: em, too_large: tl};
      frame_result_q.push_back(r);
    end
  endtask

  task automatic clear_header();
    begin
      hdr_cnt = '0;
      len_acc = '0;
      remain  = '0;
      in_body = 1'b0;
    end
  endtask

  // Advance the deframer model by one accepted stream byte
  task automatic deframe_predict(input logic [BYTE_W-1:0] b);
    begin
      if (!closed) begin
        if (!in_body) begin
          if (hdr_cnt != 0) len_acc = {len_acc[LEN_W-9:0], b};
          hdr_cnt = hdr_cnt + 1'b1;
          if (hdr_cnt == HDR_CNT_W'(HEADER_BYTES)) begin
            if (len_acc > limit_len) begin
              closed = 1'b1;
              clear_header();
              push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else if (len_acc == 0) begin
              clear_header();
              push_result('0, 1'b0, 1'b1, 1'b1, 1'b0);
            end else begin
              remain  = len_acc;
              hdr_cnt = '0;
              len_acc = '0;
              in_body = 1'b1;
            end
          end
        end else begin
          remain = remain - 1'b1;
          if (remain == 0) begin
            clear_header();
            push_result(b, 1'b1, 1'b1, 1'b0, 1'b0);
          end else begin
            push_result(b, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
      end
    end
  endtask

  // Sampling at the rising edge: check results first, then predict
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      in_fire = rst_n && in_valid && in_ready;
      if (rst_n && out_valid && out_ready) begin
        got = {out_payload_byte, out_byte_valid, out_message_end,
               out_empty_message, out_too_large};
        if (frame_result_q.size() == 0) begin
          count_error($sformatf("result with none expected: %h", got));
        end else begin
          want = frame_result_q.pop_front();
          if (got !== want)
            count_error($sformatf(
              "exp byte=%h v=%b end=%b empty=%b big=%b got byte=%h v=%b end=%b empty=%b big=%b",
              want.payload_byte, want.byte_valid, want.message_end, want.empty_message,
              want.too_large, got.payload_byte, got.byte_valid, got.message_end,
              got.empty_message, got.too_large));
        end
      end
      if (rst_n && cfg_valid && cfg_ready) limit_len = cfg_max_message_size;
      if (in_fire) begin
        taken_cnt++;
        deframe_predict(in_data_byte);
      end
    end
  end

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (!in_valid || in_fire) begin
        if (stream_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    begin
      stream_q.push_back(b);
      queued_cnt++;
    end
  endtask

  // Flag byte, then the length big-endian
  task automatic send_header(input logic [BYTE_W-1:0] flag, input logic [LEN_W-1:0] len);
    begin
      send_byte(flag);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end
  endtask

  task automatic send_message(input logic [BYTE_W-1:0] flag, input int unsigned len);
    begin
      send_header(flag, LEN_W'(len));
      repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Mostly short payloads; a few longer ones when the limit allows
  function automatic int unsigned pick_len(input logic [LEN_W-1:0] lim);
    int unsigned cap;
    int unsigned r;
    begin
      cap = (lim < 24) ? int'(lim) : 24;
      r = $urandom_range(0, 99);
      if (r < 10) pick_len = 0;
      else if (lim >= 300 && r >= 95) pick_len = $urandom_range(25, 300);
      else pick_len = $urandom_range(0, cap);
    end
  endfunction

  // Sender holds off until every byte is taken and every result has come
  task automatic wait_idle();
    begin
      @(negedge clk);
      while (taken_cnt != queued_cnt || frame_result_q.size() != 0) @(negedge clk);
      repeat (3) @(negedge clk);
    end
  endtask

  task automatic write_max(input logic [LEN_W-1:0] v);
    begin
      @(negedge clk);
      cfg_valid            <= 1'b1;
      cfg_max_message_size <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // One setting of the limit, then random messages under it
  task automatic run_phase(input logic [LEN_W-1:0] lim);
    int unsigned start;
    begin
      write_max(lim);
      start = queued_cnt;
      if (lim <= 24) send_message(BYTE_W'($urandom_range(0, 255)), int'(lim));
      while (queued_cnt - start < PHASE_BYTES)
        send_message(BYTE_W'($urandom_range(0, 255)), pick_len(lim));
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty messages, extreme flags and payload bytes, default limit
    send_message(8'h00, 0);
    send_header(8'hFF, 32'd1);
    send_byte(8'hFF);
    send_header(8'h80, 32'd2);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_message(8'h7F, 0);
    wait_idle();

    // Random phases over several limits, extremes included
    run_phase('0);
    calm = 1'b1;
    run_phase('1);
    calm = 1'b0;
    run_phase(LEN_W'($urandom_range(1, 8)));
    run_phase(LEN_W'($urandom_range(9, 40)));
    run_phase(LEN_W'(1));
    run_phase('1);

    // Back to the default limit, then one length just over it; the block
    // closes and drops everything after
    write_max(DEFAULT_MAX_MESSAGE_SIZE);
    repeat (4) send_message(BYTE_W'($urandom_range(0, 255)), pick_len(24));
    send_header(BYTE_W'($urandom_range(0, 255)), DEFAULT_MAX_MESSAGE_SIZE + 1);
    send_message(8'h00, 0);
    repeat (20) send_byte(BYTE_W'($urandom_range(0, 255)));
    wait_idle();

    repeat (10) @(posedge clk);
    if (frame_result_q.size() != 0)
      count_error($sformatf("%0d results never arrived", frame_result_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ length_prefixed_message_deframer.f @@
design/lpmd_pkg.sv
design/lpmd_parser.sv
design/length_prefixed_message_deframer.sv
tb/testbench.sv
